### rtl/core/kicker_charge_pulse_controller_macros.svh
// ---------------------------------------------------------------------------
// Kicker charge/pulse controller: assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef KICKER_CHARGE_PULSE_CONTROLLER_MACROS_SVH
`define KICKER_CHARGE_PULSE_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define KCPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("kcpc check failed");

// next-cycle implication
`define KCPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("kcpc check failed");

`else

`define KCPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define KCPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### rtl/core/kcpc_pkg.sv
// ---------------------------------------------------------------------------
// kcpc_pkg
// Types, codes and helpers shared by the kicker charge/pulse controller.
// ---------------------------------------------------------------------------
package kcpc_pkg;

	// timer width
	localparam int unsigned TIMER_BITS = 16;
	localparam int unsigned CFG_BITS   = 16;
	localparam int unsigned PCT_BITS   = 8;

	// configuration register indexes
	localparam logic [1:0] REG_CHARGE_CHECK = 2'd0;
	localparam logic [1:0] REG_TOPUP_ON     = 2'd1;
	localparam logic [1:0] REG_TOPUP_OFF    = 2'd2;

	// register reset values
	localparam logic [CFG_BITS-1:0] CHARGE_CHECK_RST = 16'd2000;
	localparam logic [CFG_BITS-1:0] TOPUP_ON_RST     = 16'd18000;
	localparam logic [CFG_BITS-1:0] TOPUP_OFF_RST    = 16'd2000;

	// item modes
	localparam logic [2:0] MODE_TICK  = 3'd0;
	localparam logic [2:0] MODE_KICK  = 3'd1;
	localparam logic [2:0] MODE_CHIP  = 3'd2;
	localparam logic [2:0] MODE_START = 3'd3;
	localparam logic [2:0] MODE_STOP  = 3'd4;

	// reported phase codes
	localparam logic [1:0] PHASE_CODE_IDLE     = 2'd0;
	localparam logic [1:0] PHASE_CODE_CHARGING = 2'd1;
	localparam logic [1:0] PHASE_CODE_READY    = 2'd2;
	localparam logic [1:0] PHASE_CODE_KICKING  = 2'd3;

	// percentage limits
	localparam logic [PCT_BITS:0] PCT_MIN = 9'd1;
	localparam logic [PCT_BITS:0] PCT_MAX = 9'd100;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'b0001,
		PH_CHARGING = 4'b0010,
		PH_READY    = 4'b0100,
		PH_KICKING  = 4'b1000
	} phase_t;

	typedef logic [TIMER_BITS-1:0] timer_t;

	// controller state
	typedef struct packed {
		phase_t phase;
		timer_t count;
		timer_t reload;
		logic   running;
		logic   toggle;
		logic   kick;
		logic   chip;
		logic   charge;
	} ctl_state_t;

	// one result item
	typedef struct packed {
		logic       kick_drive;
		logic       chip_drive;
		logic       charge_drive;
		logic [1:0] phase_out;
		logic       timer_fired;
	} result_t;

	// one-hot phase to reported code
	function automatic logic [1:0] phase_code(input phase_t ph);
		logic [1:0] code;
		unique case (ph)
			PH_IDLE:     code = PHASE_CODE_IDLE;
			PH_CHARGING: code = PHASE_CODE_CHARGING;
			PH_READY:    code = PHASE_CODE_READY;
			PH_KICKING:  code = PHASE_CODE_KICKING;
			default:     code = PHASE_CODE_IDLE;
		endcase
		return code;
	endfunction

	// clamp to 1..100
	function automatic logic [PCT_BITS-1:0] clamp_pct(input logic [PCT_BITS:0] v);
		logic [PCT_BITS:0] r;
		if (v < PCT_MIN)
			r = PCT_MIN;
		else if (v > PCT_MAX)
			r = PCT_MAX;
		else
			r = v;
		return r[PCT_BITS-1:0];
	endfunction

endpackage

### rtl/core/kicker_charge_pulse_controller.sv
// ---------------------------------------------------------------------------
// kicker_charge_pulse_controller
// Phase sequencer and countdown timer for a capacitor kicker/chipper.
// ---------------------------------------------------------------------------
// Takes one item (tick, kick, chip, start or stop) per clock and returns one
// result item per input, in the following cycle, from a result register. Throughput
// is one item every cycle: the whole state update (timer compare and
// increment, clamp of the pulse length, phase step) sits in one level of
// logic ahead of the state registers. The input stalls only while a result
// is held and the consumer stalls. Configuration writes take effect at the
// next item.

`include "kicker_charge_pulse_controller_macros.svh"

module kicker_charge_pulse_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	// input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [2:0]                      mode,
	input  logic [kcpc_pkg::PCT_BITS-1:0]   percentage,
	input  logic                            charge_done_n,
	// output channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            kick_drive,
	output logic                            chip_drive,
	output logic                            charge_drive,
	output logic [1:0]                      phase_out,
	output logic                            timer_fired,
	// configuration
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [kcpc_pkg::CFG_BITS-1:0]   cfg_data
);
	import kcpc_pkg::*;

	logic [CFG_BITS-1:0] charge_check_q;
	logic [CFG_BITS-1:0] topup_on_q;
	logic [CFG_BITS-1:0] topup_off_q;

	ctl_state_t st_q;
	ctl_state_t st_d;
	logic       fired_d;
	result_t    res_q;
	logic       out_valid_q;
	logic       in_accept;

	logic [PCT_BITS-1:0] kick_ticks;
	logic [PCT_BITS-1:0] chip_pct;
	logic [PCT_BITS-1:0] chip_ticks;

	// timer callback: step the phase and restart the timer
	function automatic ctl_state_t run_callback(input ctl_state_t s, input logic done_n,
			input logic [CFG_BITS-1:0] chk, input logic [CFG_BITS-1:0] t_on,
			input logic [CFG_BITS-1:0] t_off);
		ctl_state_t r;
		r = s;
		r.count = '0;
		unique case (s.phase)
			PH_KICKING: begin
				r.kick   = 1'b0;
				r.chip   = 1'b0;
				r.phase  = PH_CHARGING;
				r.charge = 1'b1;
				r.reload = TIMER_BITS'(chk);
			end
			PH_CHARGING: begin
				if (!done_n) begin
					r.charge = 1'b0;
					r.phase  = PH_READY;
				end
				r.reload = TIMER_BITS'(chk);
			end
			PH_READY: begin
				if (!s.toggle) begin
					r.charge = 1'b0;
					r.reload = TIMER_BITS'(t_off);
				end else begin
					r.charge = 1'b1;
					r.reload = TIMER_BITS'(t_on);
				end
				r.toggle = !s.toggle;
			end
			default: begin
				// idle: levels and reload kept
			end
		endcase
		r.running = 1'b1;
		return r;
	endfunction

	// handshake
	assign in_stall  = out_valid_q && out_stall;
	assign in_accept = in_valid && !in_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			charge_check_q <= CHARGE_CHECK_RST;
			topup_on_q     <= TOPUP_ON_RST;
			topup_off_q    <= TOPUP_OFF_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CHARGE_CHECK: charge_check_q <= cfg_data;
				REG_TOPUP_ON:     topup_on_q     <= cfg_data;
				REG_TOPUP_OFF:    topup_off_q    <= cfg_data;
				default: begin
					// index past the register list: ignored
				end
			endcase
		end
	end

	// pulse lengths: kick the clamped percentage, chip twice the clamped doubled percentage
	assign kick_ticks = clamp_pct({1'b0, percentage});
	assign chip_pct   = clamp_pct({percentage, 1'b0});
	assign chip_ticks = {chip_pct[PCT_BITS-2:0], 1'b0};

	// next state for the current item
	always_comb begin
		ctl_state_t s;
		st_d    = st_q;
		fired_d = 1'b0;
		s       = st_q;
		unique case (mode)
			MODE_TICK: begin
				if (st_q.running) begin
					if (st_q.count >= st_q.reload) begin
						st_d    = run_callback(st_q, charge_done_n, charge_check_q,
							topup_on_q, topup_off_q);
						fired_d = 1'b1;
					end else begin
						st_d.count = st_q.count + TIMER_BITS'(1);
					end
				end
			end
			MODE_KICK, MODE_CHIP: begin
				if (st_q.phase == PH_READY) begin
					st_d.phase   = PH_KICKING;
					st_d.charge  = 1'b0;
					st_d.count   = '0;
					st_d.running = 1'b1;
					if (mode == MODE_KICK) begin
						st_d.kick   = 1'b1;
						st_d.reload = TIMER_BITS'(kick_ticks);
					end else begin
						st_d.chip   = 1'b1;
						st_d.reload = TIMER_BITS'(chip_ticks);
					end
				end
			end
			MODE_START: begin
				s.phase  = PH_CHARGING;
				s.kick   = 1'b0;
				s.chip   = 1'b0;
				s.charge = 1'b1;
				s.toggle = 1'b0;
				st_d     = run_callback(s, charge_done_n, charge_check_q,
					topup_on_q, topup_off_q);
				fired_d  = 1'b1;
			end
			MODE_STOP: begin
				st_d.running = 1'b0;
				st_d.phase   = PH_IDLE;
				st_d.kick    = 1'b0;
				st_d.chip    = 1'b0;
				st_d.charge  = 1'b0;
			end
			default: begin
				// unused modes: no change
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase   <= PH_IDLE;
			st_q.count   <= '0;
			st_q.reload  <= '0;
			st_q.running <= 1'b0;
			st_q.toggle  <= 1'b0;
			st_q.kick    <= 1'b0;
			st_q.chip    <= 1'b0;
			st_q.charge  <= 1'b0;
		end else if (in_accept) begin
			st_q <= st_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			res_q.kick_drive   <= st_d.kick;
			res_q.chip_drive   <= st_d.chip;
			res_q.charge_drive <= st_d.charge;
			res_q.phase_out    <= phase_code(st_d.phase);
			res_q.timer_fired  <= fired_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign kick_drive   = res_q.kick_drive;
	assign chip_drive   = res_q.chip_drive;
	assign charge_drive = res_q.charge_drive;
	assign phase_out    = res_q.phase_out;
	assign timer_fired  = res_q.timer_fired;

	// checks
	`KCPC_ASSERT_IMP(a_one_solenoid, clk, arst_n, 1'b1, !(st_q.kick && st_q.chip))
	`KCPC_ASSERT_IMP(a_drive_kicking, clk, arst_n, (st_q.kick || st_q.chip), (st_q.phase == PH_KICKING))
	`KCPC_ASSERT_IMP(a_count_bound, clk, arst_n, st_q.running, (st_q.count <= st_q.reload))
	`KCPC_ASSERT_NXT(a_accept_result, clk, arst_n, in_accept, out_valid_q)

endmodule
